/* sv/anp_pkg.sv */
// ----------------------------------------------------------------------------
// anp_pkg: shared types and constants for the ascii number string parser
// Character codes, length limits, status codes and digit decoding.
// ----------------------------------------------------------------------------
package anp_pkg;

    // field widths
    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 64;
    localparam int POS_W   = 5;
    localparam int DIGIT_W = 4;

    // length limits, in characters
    localparam logic [POS_W-1:0] HEX_MAX_LEN = POS_W'(18);
    localparam logic [POS_W-1:0] DEC_MAX_LEN = POS_W'(10);
    localparam logic [POS_W-1:0] POS_MAX     = POS_W'(31);

    // character codes
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_F  = 8'h66;
    localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;

    // radix register codes
    localparam logic RADIX_DEC = 1'b0;
    localparam logic RADIX_HEX = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TOO_LONG = 2'd1,
        ST_BAD_CHAR = 2'd2
    } status_t;

    // decoded digit of one character
    typedef struct packed {
        logic               valid;
        logic [DIGIT_W-1:0] digit;
    } digit_t;

    // hex digit decode: 0-9, A-F, a-f
    function automatic digit_t hex_digit(input logic [CHAR_W-1:0] c);
        digit_t r;
        r.valid = 1'b1;
        r.digit = '0;
        if (c >= CH_0 && c <= CH_9) begin
            r.digit = DIGIT_W'(c - CH_0);
        end else if (c >= CH_UP_A && c <= CH_UP_F) begin
            r.digit = DIGIT_W'(c - CH_UP_A + 8'd10);
        end else if (c >= CH_LO_A && c <= CH_LO_F) begin
            r.digit = DIGIT_W'(c - CH_LO_A + 8'd10);
        end else begin
            r.valid = 1'b0;
        end
        return r;
    endfunction

    // decimal digit decode: 0-9
    function automatic digit_t dec_digit(input logic [CHAR_W-1:0] c);
        digit_t r;
        r.valid = (c >= CH_0 && c <= CH_9);
        r.digit = DIGIT_W'(c - CH_0);
        return r;
    endfunction

endpackage

/* sv/ascii_number_string_parser_unit.sv */
// ----------------------------------------------------------------------------
// ascii_number_string_parser_unit: ascii hex / decimal string to integer
// Takes one character per transaction and gives one result per string.
// ----------------------------------------------------------------------------
//
//  channel   | direction | payload                                | handshake
//  ----------+-----------+----------------------------------------+----------------
//  s_        | in        | tdata[7:0] char_code, tlast last_char  | s_tvalid/s_tready
//  m_        | out       | tdata[63:0] value, tuser[1:0] status   | m_tvalid/m_tready
//  cfg_      | in        | cfg_data radix_mode (0 dec, 1 hex)     | cfg_valid/cfg_ready
//
// One character per cycle sustained, unless a final character waits on a result. A
// character is held in the input register and the string state is updated as it
// leaves; the result of a final character is written to the output register as it leaves.
// Synchronous active-low reset sets hex mode and clears the string state.
// A waiting result stalls only a final character; other characters pass on.

module ascii_number_string_parser_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // input characters
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] char_code
    input  logic        s_tlast,    // last_char
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [63:0] value
    output logic [1:0]  m_tuser,    // [1:0] status
    // radix register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data    // radix_mode
);

    // registers
    logic                           radix_reg;
    logic                           in_valid_reg;
    logic [anp_pkg::CHAR_W-1:0]     in_char_reg;
    logic                           in_last_reg;
    logic [anp_pkg::VALUE_W-1:0]    acc_reg,     acc_next;
    logic [anp_pkg::POS_W-1:0]      pos_reg,     pos_next;
    logic                           bad_reg,     bad_next;
    logic                           fbad_reg,    fbad_next;
    logic                           stop_reg,    stop_next;
    logic                           out_valid_reg;
    logic [anp_pkg::VALUE_W-1:0]    out_value_reg, out_value_next;
    anp_pkg::status_t               out_status_reg, out_status_next;

    logic                           out_free;
    logic                           proc;
    logic                           hex_mode;
    logic                           prefix;
    anp_pkg::digit_t                hd;
    anp_pkg::digit_t                dd;
    logic [anp_pkg::VALUE_W-1:0]    acc_upd;
    logic [anp_pkg::POS_W-1:0]      limit;

    // handshakes
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign proc      = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready  = !in_valid_reg || proc;

    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_value_reg;
    assign m_tuser   = out_status_reg;

    // digit decode of the held character
    assign hex_mode = (radix_reg == anp_pkg::RADIX_HEX);
    assign hd       = anp_pkg::hex_digit(in_char_reg);
    assign dd       = anp_pkg::dec_digit(in_char_reg);
    assign prefix   = (pos_reg == anp_pkg::POS_W'(1)) && !in_last_reg
                   && (in_char_reg == anp_pkg::CH_LO_X || in_char_reg == anp_pkg::CH_UP_X);
    assign limit    = hex_mode ? anp_pkg::HEX_MAX_LEN : anp_pkg::DEC_MAX_LEN;

    // string state update and result
    always_comb begin
        acc_upd         = acc_reg;
        bad_next        = bad_reg;
        fbad_next       = fbad_reg;
        stop_next       = stop_reg;
        acc_next        = acc_reg;
        pos_next        = pos_reg;
        out_value_next  = '0;
        out_status_next = anp_pkg::ST_OK;

        if (hex_mode) begin
            if (prefix) begin
                acc_upd = '0;
                if (fbad_reg) begin
                    bad_next = 1'b0;
                end
            end else if (!hd.valid) begin
                bad_next = 1'b1;
                if (pos_reg == '0) begin
                    fbad_next = 1'b1;
                end
            end else begin
                acc_upd = {acc_reg[anp_pkg::VALUE_W-5:0], hd.digit};
            end
        end else if (!stop_reg) begin
            if (!dd.valid) begin
                stop_next = 1'b1;
            end else begin
                // times ten as shift-add
                acc_upd = {acc_reg[anp_pkg::VALUE_W-4:0], 3'b000}
                        + {acc_reg[anp_pkg::VALUE_W-2:0], 1'b0}
                        + anp_pkg::VALUE_W'(dd.digit);
            end
        end

        if (!in_last_reg) begin
            acc_next = acc_upd;
            if (pos_reg != anp_pkg::POS_MAX) begin
                pos_next = pos_reg + anp_pkg::POS_W'(1);
            end
        end else begin
            // length is position plus one
            if (pos_reg >= limit) begin
                out_status_next = anp_pkg::ST_TOO_LONG;
            end else if (hex_mode && bad_next) begin
                out_status_next = anp_pkg::ST_BAD_CHAR;
            end else begin
                out_value_next = acc_upd;
            end
            acc_next  = '0;
            pos_next  = '0;
            bad_next  = 1'b0;
            fbad_next = 1'b0;
            stop_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg     <= anp_pkg::RADIX_HEX;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            pos_reg       <= '0;
            bad_reg       <= 1'b0;
            fbad_reg      <= 1'b0;
            stop_reg      <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                radix_reg <= cfg_data;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (proc) begin
                acc_reg  <= acc_next;
                pos_reg  <= pos_next;
                bad_reg  <= bad_next;
                fbad_reg <= fbad_next;
                stop_reg <= stop_next;
            end
            if (proc && in_last_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (proc && in_last_reg) begin
            out_value_reg  <= out_value_next;
            out_status_reg <= out_status_next;
        end
    end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: regression bench for ascii_number_string_parser_unit
// Streams ASCII number strings into the parser in decimal and hex mode. A
// scoreboard class predicts one value and status per string and checks every
// result. Both stream sides idle and stall at random, in several phases.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 4;

    // expected outcome of one string
    typedef struct {
        logic [anp_pkg::VALUE_W-1:0] value;
        anp_pkg::status_t            status;
    } parsed_number_t;

    // string parse predictor and result checker
    class parse_checker;
        logic                        radix;
        logic [anp_pkg::VALUE_W-1:0] acc;
        logic [anp_pkg::POS_W-1:0]   pos;
        bit                          bad_seen;
        bit                          first_bad;
        bit                          stopped;
        parsed_number_t              awaited_numbers[$];
        int                          errors;
        int                          chars_seen;
        int                          strings_seen;
        int                          radix_writes;
        int                          status_count[3];

        function new();
            radix = anp_pkg::RADIX_HEX;
            clear_string();
        endfunction

        function void clear_string();
            acc       = '0;
            pos       = '0;
            bad_seen  = 1'b0;
            first_bad = 1'b0;
            stopped   = 1'b0;
        endfunction

        function void set_radix(logic mode);
            radix = mode;
            radix_writes++;
        endfunction

        function int outstanding();
            return awaited_numbers.size();
        endfunction

        // one accepted character transaction
        function void note_char(logic [anp_pkg::CHAR_W-1:0] c, logic is_last);
            logic [anp_pkg::DIGIT_W-1:0] nib;
            bit                          is_digit;
            int                          len;
            parsed_number_t              r;
            chars_seen++;
            if (radix == anp_pkg::RADIX_HEX) begin
                if (pos == anp_pkg::POS_W'(1) && !is_last
                        && (c == anp_pkg::CH_LO_X || c == anp_pkg::CH_UP_X)) begin
                    // prefix: restart and forgive a bad leading character
                    acc = '0;
                    if (first_bad) bad_seen = 1'b0;
                end else begin
                    is_digit = 1'b1;
                    nib      = '0;
                    if (c >= anp_pkg::CH_0 && c <= anp_pkg::CH_9) begin
                        nib = anp_pkg::DIGIT_W'(c - anp_pkg::CH_0);
                    end else if (c >= anp_pkg::CH_UP_A && c <= anp_pkg::CH_UP_F) begin
                        nib = anp_pkg::DIGIT_W'(c - anp_pkg::CH_UP_A + 10);
                    end else if (c >= anp_pkg::CH_LO_A && c <= anp_pkg::CH_LO_F) begin
                        nib = anp_pkg::DIGIT_W'(c - anp_pkg::CH_LO_A + 10);
                    end else begin
                        is_digit = 1'b0;
                    end
                    if (is_digit) begin
                        acc = {acc[anp_pkg::VALUE_W-anp_pkg::DIGIT_W-1:0], nib};
                    end else begin
                        bad_seen = 1'b1;
                        if (pos == '0) first_bad = 1'b1;
                    end
                end
            end else if (!stopped) begin
                if (c >= anp_pkg::CH_0 && c <= anp_pkg::CH_9)
                    acc = acc * 10 + anp_pkg::VALUE_W'(c - anp_pkg::CH_0);
                else stopped = 1'b1;
            end
            if (!is_last) begin
                if (pos != anp_pkg::POS_MAX) pos++;
                return;
            end
            // string complete: length check wins over bad characters
            len      = int'(pos) + 1;
            r.value  = acc;
            r.status = anp_pkg::ST_OK;
            if (len > int'(radix == anp_pkg::RADIX_HEX ? anp_pkg::HEX_MAX_LEN
                                                       : anp_pkg::DEC_MAX_LEN)) begin
                r.status = anp_pkg::ST_TOO_LONG;
                r.value  = '0;
            end else if (radix == anp_pkg::RADIX_HEX && bad_seen) begin
                r.status = anp_pkg::ST_BAD_CHAR;
                r.value  = '0;
            end
            awaited_numbers.push_back(r);
            status_count[r.status]++;
            clear_string();
        endfunction

        // one accepted result transaction
        function void check_result(logic [anp_pkg::VALUE_W-1:0] v, logic [1:0] st);
            parsed_number_t e;
            if (awaited_numbers.size() == 0) begin
                $display("%0t: result with nothing awaited: value %h status %0d", $time, v, st);
                errors++;
                return;
            end
            e = awaited_numbers.pop_front();
            strings_seen++;
            if (v !== e.value) begin
                $display("%0t: value mismatch: expected %h actual %h", $time, e.value, v);
                errors++;
            end
            if (st !== e.status) begin
                $display("%0t: status mismatch: expected %0d actual %0d", $time, e.status, st);
                errors++;
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;
    logic               s_tlast;
    logic               m_tvalid;
    logic               m_tready;
    logic [63:0]        m_tdata;
    logic [1:0]         m_tuser;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_data;

    parse_checker                sb = new();
    logic [anp_pkg::CHAR_W-1:0]  text_q[$];
    int                          send_idle_pct;
    int                          recv_stall_pct;
    bit                          hold_req;
    int                          chars_sent;

    ascii_number_string_parser_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("ascii_number_string_parser_unit regression: fail");
        $finish;
    end

    // receiver: random stalls, or a long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // monitor: every transaction on the three channels
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
            if (s_tvalid && s_tready) sb.note_char(s_tdata, s_tlast);
            if (cfg_valid && cfg_ready) sb.set_radix(cfg_data);
        end
    end

    // one character, with a random gap in front; called and returns at a falling edge
    task automatic send_char(input logic [anp_pkg::CHAR_W-1:0] c, input logic is_last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= is_last;
        do @(posedge aclk); while (!s_tready);
        chars_sent++;
        @(negedge aclk);
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++) send_char(text_q[i], i == text_q.size() - 1);
    endtask

    task automatic send_ascii(input string s);
        text_q.delete();
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
        send_text();
    endtask

    // stop offering and wait for every awaited result, then let the pipe settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_radix(input logic mode);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // random string: mostly well formed, some broken, overlong or noise
    function automatic void build_text(input logic hex_mode);
        int    kind;
        int    n;
        string digs;
        text_q.delete();
        kind = $urandom_range(99);
        digs = (hex_mode == anp_pkg::RADIX_HEX) ? "0123456789abcdefABCDEF" : "0123456789";
        if (kind < 50) begin
            if (hex_mode == anp_pkg::RADIX_HEX && $urandom_range(2) == 0) begin
                text_q.push_back(anp_pkg::CH_0);
                text_q.push_back($urandom_range(1) ? anp_pkg::CH_LO_X : anp_pkg::CH_UP_X);
                n = $urandom_range(1, 16);
            end else begin
                n = $urandom_range(1, (hex_mode == anp_pkg::RADIX_HEX) ? 18 : 10);
            end
            repeat (n) text_q.push_back(digs[$urandom_range(digs.len() - 1)]);
        end else if (kind < 56) begin
            // largest value of the mode
            n = (hex_mode == anp_pkg::RADIX_HEX) ? 16 : 10;
            repeat (n) begin
                if (hex_mode == anp_pkg::RADIX_HEX)
                    text_q.push_back($urandom_range(1) ? anp_pkg::CH_LO_F : anp_pkg::CH_UP_F);
                else text_q.push_back(anp_pkg::CH_9);
            end
        end else if (kind < 60) begin
            text_q.push_back(anp_pkg::CH_0);
        end else if (kind < 74) begin
            // one stray byte in a digit string
            n = $urandom_range(1, (hex_mode == anp_pkg::RADIX_HEX) ? 18 : 10);
            repeat (n) text_q.push_back(digs[$urandom_range(digs.len() - 1)]);
            text_q[$urandom_range(n - 1)] = anp_pkg::CHAR_W'($urandom_range(255));
        end else if (kind < 84) begin
            // overlong, past the position counter's saturation now and then
            n = $urandom_range((hex_mode == anp_pkg::RADIX_HEX) ? 19 : 11, 40);
            repeat (n) text_q.push_back(digs[$urandom_range(digs.len() - 1)]);
            if ($urandom_range(1))
                text_q[$urandom_range(n - 1)] = anp_pkg::CHAR_W'($urandom_range(255));
        end else if (kind < 90) begin
            // x in second place after a digit or a stray byte
            if ($urandom_range(1)) text_q.push_back(anp_pkg::CHAR_W'($urandom_range(255)));
            else text_q.push_back(digs[$urandom_range(digs.len() - 1)]);
            text_q.push_back($urandom_range(1) ? anp_pkg::CH_LO_X : anp_pkg::CH_UP_X);
            n = $urandom_range(0, 6);
            repeat (n) text_q.push_back(digs[$urandom_range(digs.len() - 1)]);
        end else begin
            n = $urandom_range(1, 8);
            repeat (n) text_q.push_back(anp_pkg::CHAR_W'($urandom_range(255)));
        end
    endfunction

    // stimulus
    initial begin
        logic mode;
        int   phase_start;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = anp_pkg::RADIX_HEX;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        chars_sent     = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed, hex mode from reset
        send_ascii("fF9");
        send_ascii("0xA");
        send_ascii("zX1");          // bad first character forgiven by the prefix
        send_ascii("1x");           // x as second and last character
        send_char(8'h00, 1'b1);     // nul
        send_char(8'hff, 1'b1);     // top code
        // radix change in the middle of a string
        send_char(anp_pkg::CH_UP_A, 1'b0);
        drain_results();
        write_radix(anp_pkg::RADIX_DEC);
        send_char(anp_pkg::CH_9 - 8'd2, 1'b1);
        // decimal: stop at the first non-digit
        send_ascii("1a2");
        send_ascii("x");
        send_ascii("90");

        // random phases: no idling, sender idle, receiver stalling, both
        mode = anp_pkg::RADIX_HEX;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            phase_start = chars_sent;
            while (chars_sent - phase_start < 120) begin
                drain_results();
                write_radix(mode);
                repeat ($urandom_range(3, 8)) begin
                    build_text(mode);
                    send_text();
                end
                mode = ~mode;
            end
        end

        // back pressure: long receiver hold while strings keep coming
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        drain_results();
        write_radix(anp_pkg::RADIX_HEX);
        @(posedge aclk);
        hold_req = 1'b1;
        @(negedge aclk);
        repeat (6) begin
            build_text(anp_pkg::RADIX_HEX);
            send_text();
        end
        drain_results();
        repeat (3) begin
            build_text(anp_pkg::RADIX_HEX);
            send_text();
        end

        drain_results();
        sb.errors += sb.outstanding();
        $display("covered %0d characters, %0d strings checked, %0d radix writes",
                 sb.chars_seen, sb.strings_seen, sb.radix_writes);
        $display("outcomes: %0d ok, %0d too long, %0d bad character",
                 sb.status_count[anp_pkg::ST_OK], sb.status_count[anp_pkg::ST_TOO_LONG],
                 sb.status_count[anp_pkg::ST_BAD_CHAR]);
        if (sb.errors == 0) begin
            $display("ascii_number_string_parser_unit regression: pass");
        end else begin
            $display("ascii_number_string_parser_unit regression: fail");
        end
        $finish;
    end

endmodule
